// ===== hdl/isr_pkg.sv =====
// isr_pkg: widths, register indexes, reset values and fixed-point constants
// shared by the inductor steering ratio modules; no dependencies
package isr_pkg;

  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned SUM_W      = 11;
  localparam int unsigned LEVEL_W    = 15;
  localparam int unsigned RATIO_W    = 16;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned THR_W      = 9;
  localparam int unsigned LSPEED_W   = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SIGN_W     = 2;
  localparam int unsigned NUM_LANES  = 5;

  localparam int unsigned ROUNDS_DEFAULT = 3;

  // level is sum * 256 / (2 * rounds), clamped
  localparam int unsigned LEVEL_SCALE_SH = 8;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN = 15'd256;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'd25600;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_OUTER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_MIDDLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THR    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_SPEED  = 2'd3;

  localparam logic [GAIN_W-1:0]   GAIN_OUTER_RST  = 16'd256;
  localparam logic [GAIN_W-1:0]   GAIN_MIDDLE_RST = 16'd256;
  localparam logic [THR_W-1:0]    EDGE_THR_RST    = 9'd10;
  localparam logic [LSPEED_W-1:0] LOST_SPEED_RST  = 8'd130;

  localparam logic [SIGN_W-1:0] SIGN_NONE = 2'd0;
  localparam logic [SIGN_W-1:0] SIGN_POS  = 2'd1;
  localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'd2;

  // ratio datapath
  localparam int unsigned PROD_W     = 33;
  localparam int unsigned DEN_PART_W = 32;
  localparam int unsigned NUM_W      = 34;
  localparam int unsigned DIV_DEN_W  = 33;
  localparam int unsigned RATIO_FRAC = 12;
  localparam int unsigned DIV_Q_W    = 13;
  localparam int unsigned DIV_NUM_W  = DIV_DEN_W + DIV_Q_W;
  localparam int unsigned DIV_CNT_W  = 4;

  // lost-line offset: round(4096 * (0.24 + 0.15 * q)) = round((24576 + 15360 q) / 25)
  localparam int unsigned SPD_REC_SHIFT = 23;
  localparam int unsigned SPD_REC_W     = 17;
  localparam logic [SPD_REC_W-1:0] SPD_REC = SPD_REC_W'((2**23 + 109) / 110);
  localparam int unsigned SPD_Q_W       = SPEED_W + SPD_REC_W - SPD_REC_SHIFT;
  localparam int unsigned OFS_M_W       = 23;
  localparam logic [OFS_M_W-1:0] OFS_BASE = 23'd24576;
  localparam logic [OFS_M_W-1:0] OFS_STEP = 23'd15360;
  localparam logic [OFS_M_W-1:0] OFS_RND  = 23'd12;
  localparam int unsigned OFS_REC_SHIFT = 28;
  localparam int unsigned OFS_REC_W     = 24;
  localparam logic [OFS_REC_W-1:0] OFS_REC = OFS_REC_W'((2**28 + 24) / 25);
  localparam int unsigned OFS_MAG_W     = 18;

  typedef struct packed {
    logic acc;
    logic mul;
    logic clamp;
  } lane_ctrl_t;

endpackage

// ===== hdl/inductor_steering_ratio.sv =====
// inductor_steering_ratio: top level, five channel lanes, merge of the outer
// and middle pairs, divider and lost-line offset; depends on isr_pkg,
// isr_lane, isr_lost and isr_div
//
// Use: each request on the input channel (in_valid_i / in_ready_o) is one
// scan of five samples plus the left wheel speed. Every ROUNDS-th scan
// closes a round and yields one result request on the output channel
// (out_valid_o / out_ready_i); other scans yield nothing.
// A scan that does not close a round leaves the block ready, so such scans
// may arrive back to back. The closing scan is followed by the lane multiply
// and clamp states, the merge product and sum states, a set-up state, the
// one-bit-per-cycle divider and a commit state; the result is shown in the
// cycle after the commit, and the next scan is taken in that same cycle.
// The output register holds a result until it is taken; the next round's
// scans are still accepted meanwhile, and only the commit of a new result
// waits for the receiver.
// Reset clears the scan count, channel sums, last ratio sign and held ratio,
// and restores the register defaults. The user writes the registers through
// cfg_we_i / cfg_idx_i / cfg_data_i only while no round is in progress; the block does not enforce it.
module inductor_steering_ratio import isr_pkg::*; #(
  parameter int unsigned ROUNDS = ROUNDS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [SAMPLE_W-1:0]         sample_ch0_i,
  input  logic [SAMPLE_W-1:0]         sample_ch1_i,
  input  logic [SAMPLE_W-1:0]         sample_ch2_i,
  input  logic [SAMPLE_W-1:0]         sample_ch3_i,
  input  logic [SAMPLE_W-1:0]         sample_ch4_i,
  input  logic signed [SPEED_W-1:0]   speed_left_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [LEVEL_W-1:0]          level_ch0_o,
  output logic [LEVEL_W-1:0]          level_ch1_o,
  output logic [LEVEL_W-1:0]          level_ch2_o,
  output logic [LEVEL_W-1:0]          level_ch3_o,
  output logic [LEVEL_W-1:0]          level_ch4_o,
  output logic signed [RATIO_W-1:0]   steering_ratio_o,
  output logic                        line_lost_o,
  output logic                        speed_request_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned CntW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int unsigned TotW = LEVEL_W + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LMUL = 3'd1;
  localparam logic [2:0] S_LCLP = 3'd2;
  localparam logic [2:0] S_PROD = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_PREP = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]           state_q, state_d;
  logic [CntW-1:0]      cnt_q;
  logic                 in_accept;
  logic                 final_scan;
  logic                 commit;

  logic [GAIN_W-1:0]    gain_outer_q, gain_middle_q;
  logic [THR_W-1:0]     edge_thr_q;

  lane_ctrl_t                          lane_ctrl;
  logic [NUM_LANES-1:0][SAMPLE_W-1:0]  samples;
  logic [NUM_LANES-1:0][LEVEL_W-1:0]   levels;

  logic signed [RATIO_W-1:0]  d04, d13;
  logic [RATIO_W-1:0]         s04, s13;
  logic [TotW-1:0]            total;
  logic signed [PROD_W-1:0]   numo_q, numm_q;
  logic [DEN_PART_W-1:0]      deno_q, denm_q;
  logic                       lost_q;
  logic signed [NUM_W-1:0]    num_q;
  logic [DIV_DEN_W-1:0]       den_q;
  logic [NUM_W-1:0]           num_neg;
  logic [DIV_DEN_W-1:0]       num_abs;
  logic [DIV_NUM_W-1:0]       dividend;

  logic                       div_start, div_done;
  logic [DIV_Q_W-1:0]         div_quot;
  logic [OFS_MAG_W-1:0]       ofs_mag;
  logic                       ofs_neg;

  logic [SIGN_W-1:0]          sign_q, sign_d;
  logic signed [RATIO_W-1:0]  held_q;
  logic signed [RATIO_W-1:0]  ratio_d;
  logic                       req_d;
  logic                       out_neg;

  logic                       out_valid_q;
  logic [NUM_LANES-1:0][LEVEL_W-1:0] out_level_q;
  logic signed [RATIO_W-1:0]  out_ratio_q;
  logic                       out_lost_q, out_req_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign final_scan = (cnt_q == CntW'(ROUNDS - 1));
  assign commit     = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_outer_q  <= GAIN_OUTER_RST;
      gain_middle_q <= GAIN_MIDDLE_RST;
      edge_thr_q    <= EDGE_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN_OUTER:  gain_outer_q  <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_MIDDLE: gain_middle_q <= cfg_data_i[GAIN_W-1:0];
        REG_EDGE_THR:    edge_thr_q    <= cfg_data_i[THR_W-1:0];
        // lost-line speed is applied outside the block
        REG_LOST_SPEED:  ;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_accept && final_scan) state_d = S_LMUL;
      S_LMUL: state_d = S_LCLP;
      S_LCLP: state_d = S_PROD;
      S_PROD: state_d = S_SUM;
      S_SUM:  state_d = S_PREP;
      S_PREP: state_d = S_DIV;
      S_DIV:  if (div_done) state_d = S_DONE;
      S_DONE: if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        cnt_q <= final_scan ? '0 : cnt_q + 1'b1;
      end
    end
  end

  // lanes
  assign lane_ctrl.acc   = in_accept;
  assign lane_ctrl.mul   = (state_q == S_LMUL);
  assign lane_ctrl.clamp = (state_q == S_LCLP);
  assign samples = {sample_ch4_i, sample_ch3_i, sample_ch2_i, sample_ch1_i, sample_ch0_i};

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    isr_lane #(
      .ROUNDS (ROUNDS)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .sample_i (samples[i]),
      .level_o  (levels[i])
    );
  end

  // merge of outer and middle pairs
  assign d04   = $signed({1'b0, levels[0]}) - $signed({1'b0, levels[4]});
  assign d13   = $signed({1'b0, levels[1]}) - $signed({1'b0, levels[3]});
  assign s04   = RATIO_W'(levels[0]) + RATIO_W'(levels[4]);
  assign s13   = RATIO_W'(levels[1]) + RATIO_W'(levels[3]);
  assign total = TotW'(s04) + TotW'(s13);

  always_ff @(posedge clk_i) begin
    if (state_q == S_PROD) begin
      numo_q <= PROD_W'($signed({1'b0, gain_outer_q})) * PROD_W'(d04);
      numm_q <= PROD_W'($signed({1'b0, gain_middle_q})) * PROD_W'(d13);
      deno_q <= DEN_PART_W'(gain_outer_q) * DEN_PART_W'(s04);
      denm_q <= DEN_PART_W'(gain_middle_q) * DEN_PART_W'(s13);
      lost_q <= total <= {edge_thr_q, {LEVEL_SCALE_SH{1'b0}}};
    end
    if (state_q == S_SUM) begin
      num_q <= NUM_W'(numo_q) + NUM_W'(numm_q);
      den_q <= DIV_DEN_W'(deno_q) + DIV_DEN_W'(denm_q);
    end
  end

  // |num| <= den, so the rounded quotient stays within 4096
  assign num_neg   = NUM_W'(0) - NUM_W'(num_q);
  assign num_abs   = num_q[NUM_W-1] ? num_neg[DIV_DEN_W-1:0] : num_q[DIV_DEN_W-1:0];
  assign dividend  = {num_abs, {RATIO_FRAC{1'b0}}} + DIV_NUM_W'(den_q >> 1);
  assign div_start = (state_q == S_PREP);

  isr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  isr_lost u_lost (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .speed_i (speed_left_i),
    .mag_o   (ofs_mag),
    .neg_o   (ofs_neg)
  );

  // final ratio selection
  assign out_neg = ofs_neg ^ (sign_q == SIGN_NEG);

  always_comb begin
    ratio_d = held_q;
    sign_d  = sign_q;
    req_d   = 1'b0;
    if (!lost_q) begin
      if (den_q == '0) begin
        ratio_d = '0;
        sign_d  = SIGN_NONE;
      end else begin
        ratio_d = num_q[NUM_W-1] ? -$signed(RATIO_W'(div_quot)) : $signed(RATIO_W'(div_quot));
        if (num_q == '0) begin
          sign_d = SIGN_NONE;
        end else if (num_q[NUM_W-1]) begin
          sign_d = SIGN_NEG;
        end else begin
          sign_d = SIGN_POS;
        end
      end
    end else if (sign_q == SIGN_POS || sign_q == SIGN_NEG) begin
      req_d = 1'b1;
      if (!out_neg) begin
        ratio_d = (ofs_mag > OFS_MAG_W'(32767)) ? 16'sh7FFF : $signed(ofs_mag[RATIO_W-1:0]);
      end else begin
        ratio_d = (ofs_mag > OFS_MAG_W'(32768)) ? 16'sh8000
                                                : $signed(RATIO_W'(0) - ofs_mag[RATIO_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sign_q      <= SIGN_NONE;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        sign_q      <= sign_d;
        held_q      <= ratio_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_level_q <= levels;
      out_ratio_q <= ratio_d;
      out_lost_q  <= lost_q;
      out_req_q   <= req_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign level_ch0_o      = out_level_q[0];
  assign level_ch1_o      = out_level_q[1];
  assign level_ch2_o      = out_level_q[2];
  assign level_ch3_o      = out_level_q[3];
  assign level_ch4_o      = out_level_q[4];
  assign steering_ratio_o = out_ratio_q;
  assign line_lost_o      = out_lost_q;
  assign speed_request_o  = out_req_q;

  a_div_in_div_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

  a_commit_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_o && state_q == S_IDLE)
    else $error("committed result not shown");

  a_req_needs_lost : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && speed_request_o |-> line_lost_o)
    else $error("speed request without lost line");

  a_hold_no_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && lost_q && !(sign_q == SIGN_POS || sign_q == SIGN_NEG)
    |=> steering_ratio_o == $past(held_q))
    else $error("lost line without sign did not hold ratio");

  a_partial_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !final_scan |=> state_q == S_IDLE)
    else $error("partial scan started processing");

endmodule

// ===== hdl/isr_lane.sv =====
// isr_lane: one channel lane, accumulates samples over a round and turns the
// sum into a clamped Q7.8 level; depends on isr_pkg
module isr_lane import isr_pkg::*; #(
  parameter int unsigned ROUNDS = ROUNDS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lane_ctrl_t          ctrl_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic [LEVEL_W-1:0]  level_o
);

  localparam int unsigned XW       = SUM_W + LEVEL_SCALE_SH;
  localparam int unsigned Div      = 2 * ROUNDS;
  localparam int unsigned RecShift = XW + $clog2(Div);
  localparam int unsigned MW       = XW + 1;
  localparam int unsigned PW       = XW + MW;
  localparam logic [MW-1:0] Rec =
    MW'(((64'd1 << RecShift) + 64'(Div) - 64'd1) / 64'(Div));
  localparam logic [XW-1:0] Bias = XW'(ROUNDS);

  logic [SUM_W-1:0]   sum_q;
  logic [PW-1:0]      prod_q;
  logic [LEVEL_W-1:0] level_q;
  logic [XW-1:0]      x;
  logic [PW-1:0]      quot;

  assign x    = {sum_q, {LEVEL_SCALE_SH{1'b0}}} + Bias;
  assign quot = prod_q >> RecShift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.acc) begin
      sum_q <= sum_q + SUM_W'(sample_i);
    end else if (ctrl_i.mul) begin
      sum_q <= '0;
    end
  end

  // reciprocal multiply, exact for every sum
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= PW'(x) * PW'(Rec);
    end
    if (ctrl_i.clamp) begin
      if (quot < PW'(LEVEL_MIN)) begin
        level_q <= LEVEL_MIN;
      end else if (quot > PW'(LEVEL_MAX)) begin
        level_q <= LEVEL_MAX;
      end else begin
        level_q <= quot[LEVEL_W-1:0];
      end
    end
  end

  assign level_o = level_q;

endmodule

// ===== hdl/isr_lost.sv =====
// isr_lost: lost-line steering offset magnitude and sign from wheel speed,
// four-stage pipeline of reciprocal multiplies; depends on isr_pkg
module isr_lost import isr_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [SPEED_W-1:0]  speed_i,
  output logic [OFS_MAG_W-1:0]       mag_o,
  output logic                       neg_o
);

  localparam int unsigned P1W = SPEED_W + SPD_REC_W;
  localparam int unsigned P2W = OFS_M_W + OFS_REC_W;

  logic signed [SPEED_W-1:0] speed_q;
  logic [SPEED_W-1:0]        spd_mag;
  logic [P1W-1:0]            prod1_q;
  logic                      neg1_q;
  logic [SPD_Q_W-1:0]        qmag;
  logic [OFS_M_W-1:0]        step;
  logic [OFS_M_W-1:0]        mmag_d, mmag_q;
  logic                      mneg_d, mneg_q;
  logic [P2W-1:0]            prod2_q;
  logic                      neg3_q;
  logic [OFS_MAG_W-1:0]      mag_q;
  logic                      neg_q;

  assign spd_mag = speed_q[SPEED_W-1] ? (SPEED_W'(0) - SPEED_W'(speed_q)) : SPEED_W'(speed_q);
  assign qmag    = prod1_q[SPD_REC_SHIFT +: SPD_Q_W];
  assign step    = OFS_M_W'(qmag) * OFS_STEP;

  // m = 24576 + 15360 q, kept as sign and magnitude
  always_comb begin
    if (!neg1_q) begin
      mmag_d = OFS_BASE + step;
      mneg_d = 1'b0;
    end else if (step > OFS_BASE) begin
      mmag_d = step - OFS_BASE;
      mneg_d = 1'b1;
    end else begin
      mmag_d = OFS_BASE - step;
      mneg_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= '0;
    end else if (start_i) begin
      speed_q <= speed_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod1_q <= P1W'(spd_mag) * P1W'(SPD_REC);
    neg1_q  <= speed_q[SPEED_W-1];
    mmag_q  <= mmag_d;
    mneg_q  <= mneg_d;
    prod2_q <= P2W'(mmag_q + OFS_RND) * P2W'(OFS_REC);
    neg3_q  <= mneg_q;
    mag_q   <= prod2_q[OFS_REC_SHIFT +: OFS_MAG_W];
    neg_q   <= neg3_q;
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

// ===== hdl/isr_div.sv =====
// isr_div: restoring divider, one quotient bit per cycle, quotient known to
// fit DIV_Q_W bits; depends on isr_pkg
module isr_div import isr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] dividend_i,
  input  logic [DIV_DEN_W-1:0] divisor_i,
  output logic                 done_o,
  output logic [DIV_Q_W-1:0]   quot_o
);

  logic                   busy_q;
  logic [DIV_CNT_W-1:0]   cnt_q;
  logic [DIV_DEN_W-1:0]   den_q;
  logic [DIV_DEN_W-1:0]   rem_q;
  logic [DIV_Q_W-1:0]     lo_q;
  logic [DIV_DEN_W:0]     trial;
  logic                   take;
  logic [DIV_DEN_W:0]     rem_next;

  assign trial    = {rem_q, lo_q[DIV_Q_W-1]};
  assign take     = trial >= {1'b0, den_q};
  assign rem_next = take ? (trial - {1'b0, den_q}) : trial;
  assign done_o   = busy_q && (cnt_q == DIV_CNT_W'(DIV_Q_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // low dividend bits shift out while quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= divisor_i;
      rem_q <= dividend_i[DIV_NUM_W-1:DIV_Q_W];
      lo_q  <= dividend_i[DIV_Q_W-1:0];
    end else if (busy_q) begin
      rem_q <= rem_next[DIV_DEN_W-1:0];
      lo_q  <= {lo_q[DIV_Q_W-2:0], take};
    end
  end

  assign quot_o = lo_q;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for inductor_steering_ratio, with a scan driver,
// a result monitor, an in-bench predictor of the rounds and register phases
// depends on isr_pkg and the inductor_steering_ratio top level
module testbench;
  import isr_pkg::*;

  localparam int unsigned ROUNDS = ROUNDS_DEFAULT;

  typedef struct packed {
    logic [NUM_LANES-1:0][SAMPLE_W-1:0] smp;
    logic signed [SPEED_W-1:0]          speed;
  } scan_t;

  typedef struct packed {
    logic [NUM_LANES-1:0][LEVEL_W-1:0] lvl;
    logic signed [RATIO_W-1:0]         ratio;
    logic                              lost;
    logic                              req;
  } steer_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  logic                  in_valid_q = 1'b0;
  scan_t                 tx_item = '0;
  logic                  out_ready_q = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = REG_GAIN_OUTER;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  idling = 1'b1;
  int unsigned           hold_ask = 0;

  logic                              in_ready_o;
  logic                              out_valid_o;
  logic [NUM_LANES-1:0][LEVEL_W-1:0] got_lvl;
  logic signed [RATIO_W-1:0]         steering_ratio_o;
  logic                              line_lost_o;
  logic                              speed_request_o;

  inductor_steering_ratio #(.ROUNDS(ROUNDS)) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_q),
    .in_ready_o       (in_ready_o),
    .sample_ch0_i     (tx_item.smp[0]),
    .sample_ch1_i     (tx_item.smp[1]),
    .sample_ch2_i     (tx_item.smp[2]),
    .sample_ch3_i     (tx_item.smp[3]),
    .sample_ch4_i     (tx_item.smp[4]),
    .speed_left_i     (tx_item.speed),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_q),
    .level_ch0_o      (got_lvl[0]),
    .level_ch1_o      (got_lvl[1]),
    .level_ch2_o      (got_lvl[2]),
    .level_ch3_o      (got_lvl[3]),
    .level_ch4_o      (got_lvl[4]),
    .steering_ratio_o (steering_ratio_o),
    .line_lost_o      (line_lost_o),
    .speed_request_o  (speed_request_o),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data)
  );

  scan_t      pending_scans[$];
  steer_res_t expected_results[$];
  int         fail_count = 0;

  // predictor state
  logic [GAIN_W-1:0]   wt_outer = GAIN_OUTER_RST;
  logic [GAIN_W-1:0]   wt_middle = GAIN_MIDDLE_RST;
  logic [THR_W-1:0]    edge_min = EDGE_THR_RST;
  logic [2:0]          scan_idx = '0;
  logic [SUM_W-1:0]    lane_acc [NUM_LANES];
  logic [SIGN_W-1:0]   steer_sign = SIGN_NONE;
  logic [RATIO_W-1:0]  shown_ratio = '0;

  initial for (int c = 0; c < NUM_LANES; c++) lane_acc[c] = '0;

  function automatic longint div_away(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic logic [RATIO_W-1:0] clip_ratio(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return RATIO_W'(v);
  endfunction

  function automatic void predict_scan(scan_t s);
    longint     lv [NUM_LANES];
    longint     num, den, q, base, total;
    steer_res_t r;
    r = '0;
    for (int c = 0; c < NUM_LANES; c++) lane_acc[c] = lane_acc[c] + SUM_W'(s.smp[c]);
    scan_idx = scan_idx + 3'd1;
    if (scan_idx != 3'(ROUNDS)) return;
    scan_idx = '0;
    for (int c = 0; c < NUM_LANES; c++) begin
      lv[c] = (longint'(lane_acc[c]) * 256 + ROUNDS) / (2 * ROUNDS);
      if (lv[c] < longint'(LEVEL_MIN)) lv[c] = longint'(LEVEL_MIN);
      if (lv[c] > longint'(LEVEL_MAX)) lv[c] = longint'(LEVEL_MAX);
      lane_acc[c] = '0;
      r.lvl[c] = LEVEL_W'(lv[c]);
    end
    total = lv[0] + lv[1] + lv[3] + lv[4];
    if (total > longint'(edge_min) * 256) begin
      num = longint'(wt_outer) * (lv[0] - lv[4]) + longint'(wt_middle) * (lv[1] - lv[3]);
      den = longint'(wt_outer) * (lv[0] + lv[4]) + longint'(wt_middle) * (lv[1] + lv[3]);
      if (den > 0) begin
        r.ratio = clip_ratio(div_away(num * 4096, den));
        steer_sign = (num > 0) ? SIGN_POS : ((num < 0) ? SIGN_NEG : SIGN_NONE);
      end else begin
        r.ratio = '0;
        steer_sign = SIGN_NONE;
      end
    end else begin
      r.lost = 1'b1;
      q = longint'(s.speed) / 110;
      base = div_away(98304 + 61440 * q, 100);
      if (steer_sign == SIGN_POS) begin
        r.req = 1'b1;
        r.ratio = clip_ratio(base);
      end else if (steer_sign == SIGN_NEG) begin
        r.req = 1'b1;
        r.ratio = clip_ratio(-base);
      end else begin
        r.ratio = shown_ratio;
      end
    end
    shown_ratio = r.ratio;
    expected_results.push_back(r);
  endfunction

  // driver
  int unsigned tx_gap = 0;
  always @(posedge clk_i) begin : drv
    logic nxt_valid;
    if (rst_ni) begin
      nxt_valid = in_valid_q;
      if (in_valid_q && in_ready_o) begin
        predict_scan(tx_item);
        nxt_valid = 1'b0;
        tx_gap = idling ? $urandom_range(0, 17) : 0;
      end
      if (!nxt_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_scans.size() != 0) begin
          tx_item <= pending_scans.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid_q <= nxt_valid;
    end
  end

  // monitor
  int unsigned rx_wait = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  always @(posedge clk_i) begin : mon
    steer_res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_q) begin
        if (expected_results.size() == 0) begin
          $error("result request with no expectation waiting");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          for (int c = 0; c < NUM_LANES; c++) begin
            if (got_lvl[c] !== want.lvl[c]) begin
              $error("level_ch%0d: expected %0d, actual %0d", c, want.lvl[c], got_lvl[c]);
              fail_count++;
            end
          end
          if (steering_ratio_o !== want.ratio) begin
            $error("steering_ratio: expected %0d, actual %0d", want.ratio, steering_ratio_o);
            fail_count++;
          end
          if (line_lost_o !== want.lost) begin
            $error("line_lost: expected %0d, actual %0d", want.lost, line_lost_o);
            fail_count++;
          end
          if (speed_request_o !== want.req) begin
            $error("speed_request: expected %0d, actual %0d", want.req, speed_request_o);
            fail_count++;
          end
        end
        rx_wait = idling ? $urandom_range(0, 17) : 0;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = 400;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_ready_q <= (rx_wait == 0 && hold_left == 0);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      REG_GAIN_OUTER:  wt_outer = data[GAIN_W-1:0];
      REG_GAIN_MIDDLE: wt_middle = data[GAIN_W-1:0];
      REG_EDGE_THR:    edge_min = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [15:0] go, logic [15:0] gm, logic [15:0] thr,
                              logic [15:0] spd);
    write_reg(REG_GAIN_OUTER, go);
    write_reg(REG_GAIN_MIDDLE, gm);
    write_reg(REG_EDGE_THR, thr);
    write_reg(REG_LOST_SPEED, spd);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_scans.size() != 0 || in_valid_q || expected_results.size() != 0);
    repeat (25) @(posedge clk_i);
  endtask

  function automatic void push_round(logic [NUM_LANES-1:0][SAMPLE_W-1:0] smp,
                                     logic signed [SPEED_W-1:0] spd);
    scan_t s;
    s.smp = smp;
    s.speed = spd;
    for (int k = 0; k < ROUNDS; k++) pending_scans.push_back(s);
  endfunction

  initial begin : stim
    scan_t       sc;
    int          mode;
    logic [15:0] go, gm, thr, spd;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed rounds under reset values, samples listed ch4 down to ch0
    push_round({8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 16'sd0);
    push_round({8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 16'sh7FFF);
    push_round({8'd0, 8'd10, 8'd77, 8'd200, 8'd255}, 16'sd109);
    push_round({8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 16'sh7FFF);
    push_round({8'd1, 8'd2, 8'd255, 8'd3, 8'd1}, 16'sh8000);
    push_round({8'd255, 8'd200, 8'd128, 8'd10, 8'd0}, -16'sd110);
    push_round({8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 16'sh8000);
    push_round({8'd2, 8'd1, 8'd0, 8'd0, 8'd1}, 16'sd0);
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: program_regs(16'd256, 16'd256, 16'd10, 16'd130);
        1: program_regs(16'd0, 16'd0, 16'd0, 16'd0);
        2: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: program_regs(16'd0, 16'hFFFF, 16'd400, 16'd17);
        4: program_regs(16'hFFFF, 16'd0, 16'd1, 16'd200);
        default: begin
          go = 16'($urandom);
          gm = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
          thr = {7'($urandom),
                 (ph % 2 != 0) ? 9'($urandom_range(0, 40)) : 9'($urandom_range(0, 511))};
          spd = 16'($urandom);
          program_regs(go, gm, thr, spd);
        end
      endcase
      idling <= !(ph == 6 || ph == 8);
      if (ph == 6) hold_ask <= hold_ask + 1;
      for (int r = 0; r < 45; r++) begin
        mode = $urandom_range(0, 9);
        for (int k = 0; k < ROUNDS; k++) begin
          for (int c = 0; c < NUM_LANES; c++) begin
            case (mode)
              0, 1, 2: sc.smp[c] = 8'($urandom_range(0, 7));
              6: sc.smp[c] = (c < 2) ? 8'($urandom_range(100, 255)) : 8'($urandom_range(0, 60));
              7: sc.smp[c] = (c > 2) ? 8'($urandom_range(100, 255)) : 8'($urandom_range(0, 60));
              8: sc.smp[c] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
              default: sc.smp[c] = 8'($urandom);
            endcase
          end
          case ($urandom_range(0, 5))
            0, 1, 2: sc.speed = 16'($urandom);
            3: sc.speed = 16'(int'($urandom_range(0, 1000)) - 500);
            4: sc.speed = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            default: sc.speed = ($urandom_range(0, 1) != 0) ? 16'sh0000 : 16'shFFFF;
          endcase
          pending_scans.push_back(sc);
        end
      end
      wait_drained();
    end

    if (fail_count == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/isr_pkg.sv
hdl/isr_lane.sv
hdl/isr_lost.sv
hdl/isr_div.sv
hdl/inductor_steering_ratio.sv
dv/testbench.sv
